@@ sv/bmaps_pkg.sv @@
// Shared types and constants for the block peak-magnitude reducer.
package bmaps_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int TRACE_W     = 8;
	localparam int BS_W        = 9;
	localparam int SC_W        = 13;
	localparam int CFG_DATA_W  = 13;
	localparam int CNT_W       = 17;
	localparam int IN_Q_DEPTH  = 2;
	localparam int OUT_Q_DEPTH = 4;

	localparam logic [BS_W-1:0] BS_RESET = 9'd1;
	localparam logic [SC_W-1:0] SC_RESET = 13'd4096;

	typedef enum logic [0:0] {
		REG_BLOCK_SIZE   = 1'b0,
		REG_SAMPLE_COUNT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic first;
		logic emit;
		logic block_end;
	} cmd_flags_t;

endpackage

@@ sv/bmaps_queue.sv @@
// Small synchronous FIFO with occupancy count.
module bmaps_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [W-1:0]               push_data,
	input  logic                       pop,
	output logic [W-1:0]               pop_data,
	output logic                       empty,
	output logic                       full,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign empty    = (count_q == CW'(0));
	assign full     = (count_q == CW'(DEPTH));
	assign count    = count_q;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

@@ sv/bmaps_front.sv @@
// Front end: config registers, position/trace counters and word classification.
module bmaps_front #(
	parameter int MAX_SAMPLES = 4096,
	parameter int MAX_BLOCK   = 256,
	parameter int PW          = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  bmaps_pkg::cfg_reg_t                  cfg_index,
	input  logic [bmaps_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                 accept,
	input  logic [bmaps_pkg::SAMPLE_W-1:0]       sample,
	output logic [PW-1:0]                        cmd_addr,
	output logic [bmaps_pkg::SAMPLE_W-1:0]       cmd_mag,
	output logic [bmaps_pkg::TRACE_W-1:0]        cmd_trace,
	output bmaps_pkg::cmd_flags_t                cmd_flags
);
	import bmaps_pkg::*;

	localparam int TW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

	logic [BS_W-1:0]  block_size_q;
	logic [SC_W-1:0]  sample_count_q;
	logic [PW-1:0]    pos_q;
	logic [TW-1:0]    trace_q;
	logic [CNT_W-1:0] ns_eff, nb_eff;
	logic             last_pos, last_trace;

	always_comb begin
		if (sample_count_q == '0) begin
			ns_eff = CNT_W'(1);
		end else if (CNT_W'(sample_count_q) > CNT_W'(MAX_SAMPLES)) begin
			ns_eff = CNT_W'(MAX_SAMPLES);
		end else begin
			ns_eff = CNT_W'(sample_count_q);
		end
		if (block_size_q == '0) begin
			nb_eff = CNT_W'(1);
		end else if (CNT_W'(block_size_q) > CNT_W'(MAX_BLOCK)) begin
			nb_eff = CNT_W'(MAX_BLOCK);
		end else begin
			nb_eff = CNT_W'(block_size_q);
		end
		last_pos   = (CNT_W'(pos_q) + CNT_W'(1)) >= ns_eff;
		last_trace = (CNT_W'(trace_q) + CNT_W'(1)) >= nb_eff;
	end

	assign cmd_addr  = pos_q;
	assign cmd_mag   = sample[SAMPLE_W-1] ? SAMPLE_W'(~sample + SAMPLE_W'(1)) : sample;
	assign cmd_trace = TRACE_W'(trace_q);
	assign cmd_flags = '{first: (trace_q == '0), emit: last_trace, block_end: last_pos};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q   <= BS_RESET;
			sample_count_q <= SC_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BLOCK_SIZE:   block_size_q   <= BS_W'(cfg_data);
				REG_SAMPLE_COUNT: sample_count_q <= SC_W'(cfg_data);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			trace_q <= '0;
		end else if (accept) begin
			if (last_pos) begin
				pos_q   <= '0;
				trace_q <= last_trace ? '0 : trace_q + TW'(1);
			end else begin
				pos_q <= pos_q + PW'(1);
			end
		end
	end

endmodule

@@ sv/bmaps_back.sv @@
// Back end: peak memory read-modify-write with one-deep bypass.
module bmaps_back #(
	parameter int MAX_SAMPLES = 4096,
	parameter int PW          = 12
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       q_empty,
	input  logic [PW-1:0]                              q_addr,
	input  logic [bmaps_pkg::SAMPLE_W-1:0]             q_mag,
	input  logic [bmaps_pkg::TRACE_W-1:0]              q_trace,
	input  bmaps_pkg::cmd_flags_t                      q_flags,
	output logic                                       q_pop,
	input  logic [$clog2(bmaps_pkg::OUT_Q_DEPTH+1)-1:0] out_count,
	output logic                                       res_push,
	output logic [bmaps_pkg::SAMPLE_W+bmaps_pkg::TRACE_W-1:0] res_data,
	output logic                                       res_last
);
	import bmaps_pkg::*;

	localparam int DW = SAMPLE_W + TRACE_W;
	localparam int OCW = $clog2(OUT_Q_DEPTH + 1) + 1;

	logic [DW-1:0]       peak_mem_q [MAX_SAMPLES];
	logic                valid_s1;
	logic [PW-1:0]       addr_s1;
	logic [SAMPLE_W-1:0] mag_s1;
	logic [TRACE_W-1:0]  trace_s1;
	cmd_flags_t          flags_s1;
	logic [DW-1:0]       rd_s1;
	logic                byp_s1;
	logic [DW-1:0]       byp_data_s1;
	logic [DW-1:0]       old_word, new_word;

	// reserve an output slot for every word in flight
	assign q_pop = !q_empty && ((OCW'(out_count) + OCW'(valid_s1)) < OCW'(OUT_Q_DEPTH));

	always_comb begin
		old_word = byp_s1 ? byp_data_s1 : rd_s1;
		if (flags_s1.first) begin
			new_word = {TRACE_W'(0), mag_s1};
		end else if (mag_s1 > old_word[SAMPLE_W-1:0]) begin
			new_word = {trace_s1, mag_s1};
		end else begin
			new_word = old_word;
		end
	end

	assign res_push = valid_s1 && flags_s1.emit;
	assign res_data = new_word;
	assign res_last = flags_s1.block_end;

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			peak_mem_q[addr_s1] <= new_word;
		end
		if (q_pop) begin
			rd_s1 <= peak_mem_q[q_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			addr_s1     <= q_addr;
			mag_s1      <= q_mag;
			trace_s1    <= q_trace;
			flags_s1    <= q_flags;
			byp_s1      <= valid_s1 && (addr_s1 == q_addr);
			byp_data_s1 <= new_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= q_pop;
		end
	end

endmodule

@@ sv/block_max_abs_per_sample_unit.sv @@
// Results pass the command queue, the memory read stage and the result queue to the output.
// Throughput: one word per cycle while queues have room; one memory read and write per cycle.
// Stalls on the output are absorbed by a 4-word result queue and a 2-word command queue.
// Reset clears the counters, queues and config (block_size 1, sample_count 4096);
// the peak memory is not cleared and holds whatever it held until written.
module block_max_abs_per_sample_unit #(
	parameter int MAX_SAMPLES = 4096,
	parameter int MAX_BLOCK   = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  bmaps_pkg::cfg_reg_t              cfg_index,
	input  logic [bmaps_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [15:0]                      s_axis_tdata,  // sample_value
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [23:0]                      m_axis_tdata,  // peak_magnitude, peak_trace
	output logic                             m_axis_tlast   // block_end
);
	import bmaps_pkg::*;

	localparam int PW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CFW = $bits(cmd_flags_t);
	localparam int IQW = PW + SAMPLE_W + TRACE_W + CFW;
	localparam int OQW = SAMPLE_W + TRACE_W + 1;

	logic                accept;
	logic [PW-1:0]       f_addr, b_addr;
	logic [SAMPLE_W-1:0] f_mag, b_mag;
	logic [TRACE_W-1:0]  f_trace, b_trace;
	cmd_flags_t          f_flags, b_flags;
	logic [IQW-1:0]      iq_out;
	logic                iq_empty, iq_full, iq_pop;
	logic [$clog2(IN_Q_DEPTH+1)-1:0]  iq_count;
	logic [$clog2(OUT_Q_DEPTH+1)-1:0] oq_count;
	logic                oq_empty, oq_full;
	logic                res_push, res_last;
	logic [SAMPLE_W+TRACE_W-1:0] res_data;
	logic [OQW-1:0]      oq_out;

	assign s_axis_tready = !iq_full;
	assign accept        = s_axis_tvalid && !iq_full;

	bmaps_front #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.MAX_BLOCK  (MAX_BLOCK),
		.PW         (PW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.sample   (s_axis_tdata),
		.cmd_addr (f_addr),
		.cmd_mag  (f_mag),
		.cmd_trace(f_trace),
		.cmd_flags(f_flags)
	);

	bmaps_queue #(
		.W    (IQW),
		.DEPTH(IN_Q_DEPTH)
	) u_cmd_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_data({f_flags, f_trace, f_mag, f_addr}),
		.pop      (iq_pop),
		.pop_data (iq_out),
		.empty    (iq_empty),
		.full     (iq_full),
		.count    (iq_count)
	);

	assign {b_flags, b_trace, b_mag, b_addr} = iq_out;

	bmaps_back #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.PW         (PW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (iq_empty),
		.q_addr   (b_addr),
		.q_mag    (b_mag),
		.q_trace  (b_trace),
		.q_flags  (b_flags),
		.q_pop    (iq_pop),
		.out_count(oq_count),
		.res_push (res_push),
		.res_data (res_data),
		.res_last (res_last)
	);

	bmaps_queue #(
		.W    (OQW),
		.DEPTH(OUT_Q_DEPTH)
	) u_res_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_push),
		.push_data({res_last, res_data}),
		.pop      (m_axis_tready),
		.pop_data (oq_out),
		.empty    (oq_empty),
		.full     (oq_full),
		.count    (oq_count)
	);

	assign m_axis_tvalid = !oq_empty;
	assign m_axis_tdata  = oq_out[SAMPLE_W+TRACE_W-1:0];
	assign m_axis_tlast  = oq_out[OQW-1];

endmodule

@@ verif/tb_top.sv @@
// Self-checking bench for the block peak-magnitude reducer: random stream traffic, tracked peaks.
`timescale 1ns / 1ps

module tb_top;
	import bmaps_pkg::*;

	localparam int MAX_SAMPLES = 4096;
	localparam int MAX_BLOCK   = 256;
	localparam int RAND_WORDS  = 2000;
	localparam int SETTLE_CYC  = 10;
	localparam longint CYCLE_LIMIT = 8_000_000;

	typedef struct packed {
		logic [15:0] mag;
		logic [7:0]  trc;
		logic        last;
	} peak_word_t;

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  cfg_we        = 1'b0;
	cfg_reg_t              cfg_index     = REG_BLOCK_SIZE;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [15:0]           s_axis_tdata  = '0;  // sample_value
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [23:0]           m_axis_tdata;        // peak_magnitude, peak_trace
	logic                  m_axis_tlast;        // block_end

	logic [15:0] sample_backlog [$];
	peak_word_t  pending_peaks [$];

	logic [15:0] peak_mag_mem [0:MAX_SAMPLES-1];
	logic [7:0]  peak_trc_mem [0:MAX_SAMPLES-1];
	int          pos_cnt = 0;
	int          trc_cnt = 0;
	logic [8:0]  bs_reg  = BS_RESET;
	logic [12:0] sc_reg  = SC_RESET;

	int     words_offered = 0;
	int     words_taken   = 0;
	int     random_pushed = 0;
	int     in_gap        = 0;
	int     out_gap       = 0;
	int     err_cnt       = 0;
	bit     calm          = 1'b0;
	longint cycle_cnt     = 0;

	block_max_abs_per_sample_unit #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.MAX_BLOCK  (MAX_BLOCK)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int block_eff();
		if (bs_reg == 0) return 1;
		if (bs_reg > MAX_BLOCK) return MAX_BLOCK;
		return int'(bs_reg);
	endfunction

	function automatic int count_eff();
		if (sc_reg == 0) return 1;
		if (sc_reg > MAX_SAMPLES) return MAX_SAMPLES;
		return int'(sc_reg);
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] rand_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			case ($urandom_range(0, 5))
				0: return 16'h8000;
				1: return 16'h7FFF;
				2: return 16'h0000;
				3: return 16'hFFFF;
				4: return 16'h8001;
				default: return 16'h0001;
			endcase
		end
		// narrow range so ties on magnitude come up often
		if (r < 40) return 16'(int'($urandom_range(0, 16)) - 8);
		return 16'($urandom);
	endfunction

	task automatic fold_sample(input logic [15:0] raw);
		logic [15:0] mag;
		int          nb, ns, slot;
		bit          end_pos, end_trace;
		mag = raw[15] ? (~raw + 16'd1) : raw;
		nb = block_eff();
		ns = count_eff();
		slot = (pos_cnt < MAX_SAMPLES) ? pos_cnt : MAX_SAMPLES - 1;
		end_pos = (pos_cnt + 1 >= ns);
		end_trace = (trc_cnt + 1 >= nb);
		if (trc_cnt == 0) begin
			peak_mag_mem[slot] = mag;
			peak_trc_mem[slot] = '0;
		end else if (mag > peak_mag_mem[slot]) begin
			peak_mag_mem[slot] = mag;
			peak_trc_mem[slot] = 8'(trc_cnt);
		end
		if (end_trace)
			pending_peaks.push_back(peak_word_t'({peak_mag_mem[slot], peak_trc_mem[slot], end_pos}));
		if (end_pos) begin
			pos_cnt = 0;
			trc_cnt = end_trace ? 0 : trc_cnt + 1;
		end else begin
			pos_cnt++;
		end
	endtask

	task automatic push_random(input int n);
		repeat (n) sample_backlog.push_back(rand_sample());
		random_pushed += n;
	endtask

	task automatic settle();
		@(negedge clk);
		while (sample_backlog.size() != 0 || words_taken != words_offered ||
				pending_peaks.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [12:0] val);
		settle();
		cfg_index <= idx;
		cfg_data <= val;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_BLOCK_SIZE)
			bs_reg = val[8:0];
		else
			sc_reg = val;
	endtask

	// pad the stream out to the next block boundary
	task automatic close_block();
		int nb, ns, n;
		settle();
		nb = block_eff();
		ns = count_eff();
		n = (pos_cnt + 1 >= ns) ? 1 : ns - pos_cnt;
		if (trc_cnt + 1 < nb) n += (nb - trc_cnt - 1) * ns;
		if (pos_cnt != 0 || trc_cnt != 0) push_random(n);
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (s_axis_tvalid && words_taken != words_offered) begin
			// word still on offer
		end else if (in_gap > 0) begin
			s_axis_tvalid <= 1'b0;
			in_gap--;
		end else if (sample_backlog.size() != 0) begin
			s_axis_tdata <= sample_backlog.pop_front();
			s_axis_tvalid <= 1'b1;
			words_offered++;
			in_gap = pick_gap();
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (out_gap > 0) begin
			m_axis_tready <= 1'b0;
			out_gap--;
		end else begin
			m_axis_tready <= 1'b1;
			out_gap = pick_gap();
		end
	end

	always @(posedge clk) begin : monitor
		peak_word_t got, want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = peak_word_t'({m_axis_tdata[15:0], m_axis_tdata[23:16], m_axis_tlast});
				if (pending_peaks.size() == 0) begin
					if (err_cnt < 50)
						$display("%0t: unexpected word: expected none, actual mag %0d trace %0d end %0b",
							$time, got.mag, got.trc, got.last);
					err_cnt++;
				end else begin
					want = pending_peaks.pop_front();
					if (got !== want) begin
						if (err_cnt < 50)
							$display("%0t: mismatch: expected mag %0d trace %0d end %0b, actual mag %0d trace %0d end %0b",
								$time, want.mag, want.trc, want.last, got.mag, got.trc, got.last);
						err_cnt++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				fold_sample(s_axis_tdata);
				words_taken++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		int r, bsv, nsv, blk, nblk;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: one trace of 4096 per block, cut short part way through
		sample_backlog.push_back(16'h8000);
		sample_backlog.push_back(16'h7FFF);
		sample_backlog.push_back(16'h0000);
		sample_backlog.push_back(16'hFFFF);
		sample_backlog.push_back(16'h0001);
		sample_backlog.push_back(16'h8001);
		write_reg(REG_SAMPLE_COUNT, 13'd8);
		close_block();

		// ties, strict replacement, first-trace overwrite of stale entries
		write_reg(REG_BLOCK_SIZE, 13'd3);
		write_reg(REG_SAMPLE_COUNT, 13'd4);
		sample_backlog.push_back(16'd5);
		sample_backlog.push_back(16'h8000);
		sample_backlog.push_back(16'h7FFF);
		sample_backlog.push_back(16'd0);
		sample_backlog.push_back(16'hFFFB);
		sample_backlog.push_back(16'h7FFF);
		sample_backlog.push_back(16'h8000);
		sample_backlog.push_back(16'hFFFF);
		sample_backlog.push_back(16'd6);
		sample_backlog.push_back(16'h8000);
		sample_backlog.push_back(16'h8001);
		sample_backlog.push_back(16'h0001);

		// block size zero
		write_reg(REG_BLOCK_SIZE, 13'd0);
		write_reg(REG_SAMPLE_COUNT, 13'd2);
		sample_backlog.push_back(16'hFFFF);
		sample_backlog.push_back(16'h7FFF);
		sample_backlog.push_back(16'h8000);
		sample_backlog.push_back(16'h0000);

		// sample count zero
		write_reg(REG_BLOCK_SIZE, 13'd2);
		write_reg(REG_SAMPLE_COUNT, 13'd0);
		sample_backlog.push_back(16'h0003);
		sample_backlog.push_back(16'hFFFD);
		sample_backlog.push_back(16'h8000);
		sample_backlog.push_back(16'h7FFF);

		// limits lowered part way through a block
		write_reg(REG_BLOCK_SIZE, 13'd4);
		write_reg(REG_SAMPLE_COUNT, 13'd6);
		push_random(9);
		write_reg(REG_SAMPLE_COUNT, 13'd2);
		write_reg(REG_BLOCK_SIZE, 13'd2);
		close_block();

		// largest block, then over-range block size with upper data bits set
		write_reg(REG_BLOCK_SIZE, 13'd256);
		write_reg(REG_SAMPLE_COUNT, 13'd3);
		push_random(768);
		write_reg(REG_BLOCK_SIZE, 13'h1FFF);
		write_reg(REG_SAMPLE_COUNT, 13'd1);
		push_random(256);

		// over-range sample count
		write_reg(REG_BLOCK_SIZE, 13'd1);
		write_reg(REG_SAMPLE_COUNT, 13'h1FFF);
		push_random(MAX_SAMPLES);

		random_pushed = 0;
		while (random_pushed < RAND_WORDS) begin
			close_block();
			calm = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 80) begin
				bsv = $urandom_range(1, 8);
				nsv = $urandom_range(1, 16);
			end else if (r < 85) begin
				bsv = 0;
				nsv = $urandom_range(1, 16);
			end else if (r < 90) begin
				bsv = $urandom_range(1, 4);
				nsv = 0;
			end else if (r < 95) begin
				bsv = $urandom_range(200, 511);
				nsv = $urandom_range(1, 2);
			end else begin
				bsv = $urandom_range(1, 3);
				nsv = $urandom_range(17, 300);
			end
			write_reg(REG_BLOCK_SIZE, {4'($urandom), 9'(bsv)});
			write_reg(REG_SAMPLE_COUNT, 13'(nsv));
			blk = block_eff() * count_eff();
			nblk = (blk > 200) ? 1 : $urandom_range(1, 3);
			push_random(nblk * blk);
			// never raise the sample count mid-block: raising it would read unwritten entries
			if ($urandom_range(0, 2) == 0 && blk > 1) begin
				push_random($urandom_range(1, blk - 1));
				if ($urandom_range(0, 1) == 1)
					write_reg(REG_SAMPLE_COUNT, 13'($urandom_range(0, count_eff())));
				else
					write_reg(REG_BLOCK_SIZE, 13'($urandom_range(0, 20)));
			end
		end
		close_block();
		settle();

		if (err_cnt == 0 && pending_peaks.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ files.f @@
sv/bmaps_pkg.sv
sv/bmaps_queue.sv
sv/bmaps_front.sv
sv/bmaps_back.sv
sv/block_max_abs_per_sample_unit.sv
verif/tb_top.sv
